### hdl/tfsd_pkg.sv
package tfsd_pkg;

  // Default number of entries in the store.
  localparam int unsigned DEPTH_DEF = 16;

  // Field widths.
  localparam int unsigned TAG_W = 16;
  localparam int unsigned OCC_W = 5;

  // Operation codes carried by an input transfer.
  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_TAKE_KIND = 2'd1,
    OP_TAKE_ANY  = 2'd2
  } opcode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // One stored entry.
  typedef struct packed {
    logic             kind;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Command broadcast to every cell of the chain in the same cycle.
  typedef struct packed {
    logic             add;
    logic             take;
    logic             any;
    logic             kind;
    logic [TAG_W-1:0] tag;
  } cell_cmd_t;

endpackage

### hdl/tfsd_cell.sv
module tfsd_cell
  import tfsd_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [CNT_W-1:0] count,
  input  logic             hit_in,
  input  entry_t           sel_in,
  input  entry_t           nxt_entry,
  output logic             hit_out,
  output entry_t           sel_out,
  output entry_t           entry_out
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   occupied;
  logic   tail;
  logic   match;

  // Position of this cell relative to the fill level.
  assign occupied = count > CNT_W'(IDX);
  assign tail     = count == CNT_W'(IDX);

  // During a take, this cell matches if it holds an entry of the wanted kind, or any entry for a take of any kind.
  assign match = occupied & cmd.take & (cmd.any | (entry_r.kind == cmd.kind));

  // The oldest match claims the removal; younger cells only pass it on.
  assign hit_out = hit_in | match;
  assign sel_out = (match & ~hit_in) ? entry_r : sel_in;

  // Append at the tail, or close the gap from the younger neighbor.
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.add & tail) begin
      entry_nxt.kind = cmd.kind;
      entry_nxt.tag  = cmd.tag;
    end else if (hit_out) begin
      entry_nxt = nxt_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_out = entry_r;

endmodule

### hdl/typed_fifo_selective_dequeue.sv
// Two-kind ordered queue with selective removal. Up to DEPTH entries of
// kind and tag are kept in arrival order in a row of cells, oldest first.
// An add appends at the tail; a take of one kind removes the oldest entry
// of that kind, and a take of any kind removes the oldest entry; the
// younger entries shift down one cell to close the gap. Every input
// transfer yields exactly one result in the next cycle (status, removed
// entry, occupancy), and a new item is accepted every cycle while the
// result register is free or being read. The per-cycle path is the
// first-match search rippling through all DEPTH cells. An add to a full
// store is dropped with status full; a failed take changes nothing.
module typed_fifo_selective_dequeue
  import tfsd_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_opcode,
  input  logic             in_kind,
  input  logic [TAG_W-1:0] in_pet_tag,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_status,
  output logic             out_kind,
  output logic [TAG_W-1:0] out_tag,
  output logic [OCC_W-1:0] out_occupancy
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic             accept;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             full;
  cell_cmd_t        cmd;
  status_t          status;
  logic             is_add;
  logic             is_take;
  logic             is_any;

  logic             hit   [DEPTH+1];
  entry_t           sel   [DEPTH+1];
  entry_t           entry [DEPTH+1];

  logic             out_valid_r;
  logic             out_valid_nxt;
  status_t          status_r;
  entry_t           res_r;
  logic [CNT_W-1:0] occ_r;
  logic [CNT_W+OCC_W-1:0] occ_ext;

  // Input transfer happens whenever the result register can take a result.
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign full     = count_r == CNT_W'(DEPTH);

  // Opcode decode.
  always_comb begin
    is_add  = 1'b0;
    is_take = 1'b0;
    is_any  = 1'b0;
    unique case (opcode_t'(in_opcode))
      OP_ADD:       is_add  = 1'b1;
      OP_TAKE_KIND: is_take = 1'b1;
      OP_TAKE_ANY: begin
        is_take = 1'b1;
        is_any  = 1'b1;
      end
      default: ;
    endcase
  end

  // Command to the cells; only a transfer acts on the store.
  assign cmd.add  = accept & is_add & ~full;
  assign cmd.take = accept & is_take;
  assign cmd.any  = is_any;
  assign cmd.kind = in_kind;
  assign cmd.tag  = in_pet_tag;

  // Chain of cells, oldest at index zero.
  assign hit[0]       = 1'b0;
  assign sel[0]       = '0;
  assign entry[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    tfsd_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count_r),
      .hit_in    (hit[i]),
      .sel_in    (sel[i]),
      .nxt_entry (entry[i+1]),
      .hit_out   (hit[i+1]),
      .sel_out   (sel[i+1]),
      .entry_out (entry[i])
    );
  end

  // Fill level and status of this item.
  always_comb begin
    count_nxt = count_r;
    status    = ST_NONE;
    if (is_add) begin
      if (full) begin
        status = ST_FULL;
      end else begin
        status    = ST_OK;
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (hit[DEPTH]) begin
      status    = ST_OK;
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // Result register.
  assign out_valid_nxt = accept | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status;
      res_r    <= sel[DEPTH];
      occ_r    <= count_nxt;
    end
  end

  assign occ_ext       = {{OCC_W{1'b0}}, occ_r};
  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_kind      = res_r.kind;
  assign out_tag       = res_r.tag;
  assign out_occupancy = occ_ext[OCC_W-1:0];

endmodule
